// ----- rtl/tbp_pkg.sv -----
// ----------------------------------------------------------------------------
// tbp_pkg
// shared types, constants and helper functions of the tage branch predictor
// ----------------------------------------------------------------------------
`default_nettype none

package tbp_pkg;

  localparam int TAG_IDX_BITS = 10;
  localparam int BIM_IDX_BITS = 12;
  localparam int NUM_TAGGED   = 4;
  localparam int PATH_BITS    = 16;
  localparam int LONGEST      = 130;
  localparam int MAX_TAG_BITS = 12;

  localparam int TAG_SIZE = 1 << TAG_IDX_BITS;
  localparam int BIM_SIZE = 1 << BIM_IDX_BITS;
  localparam int CLR_BITS = (BIM_IDX_BITS > TAG_IDX_BITS) ? BIM_IDX_BITS : TAG_IDX_BITS;
  localparam int UCNT_BITS = TAG_IDX_BITS + 1;

  localparam int HIST0 = (130 < LONGEST) ? 130 : LONGEST;
  localparam int HIST1 = (44 < LONGEST) ? 44 : LONGEST;
  localparam int HIST2 = (15 < LONGEST) ? 15 : LONGEST;
  localparam int HIST3 = (5 < LONGEST) ? 5 : LONGEST;
  localparam int HIST [NUM_TAGGED] = '{HIST0, HIST1, HIST2, HIST3};

  localparam int TW0 = MAX_TAG_BITS;
  localparam int TW3 = MAX_TAG_BITS - 1;
  localparam int TAG_W [NUM_TAGGED] = '{TW0, TW0, TW0, TW3};

  localparam int FI_SH [NUM_TAGGED] = '{HIST0 % TAG_IDX_BITS, HIST1 % TAG_IDX_BITS,
                                        HIST2 % TAG_IDX_BITS, HIST3 % TAG_IDX_BITS};
  localparam int FT0_SH [NUM_TAGGED] = '{HIST0 % TW0, HIST1 % TW0, HIST2 % TW0, HIST3 % TW3};
  localparam int FT1_SH [NUM_TAGGED] = '{HIST0 % (TW0 - 1), HIST1 % (TW0 - 1),
                                         HIST2 % (TW0 - 1), HIST3 % (TW3 - 1)};

  localparam logic [2:0]  CTR_MAX  = 3'd7;
  localparam logic [2:0]  WEAK_T   = 3'd4;
  localparam logic [2:0]  WEAK_NT  = 3'd3;
  localparam logic [1:0]  U_MAX    = 2'd3;
  localparam logic [3:0]  ALT_MAX  = 4'd15;
  localparam logic [3:0]  ALT_INIT = 4'd8;
  localparam logic [1:0]  BIM_INIT = 2'd2;
  localparam logic [15:0] LFSR_MASK = 16'hB400;
  localparam logic [2:0]  PROV_BIM = 3'd4;

  localparam logic [3:0]  RST_ALT_THR = 4'd8;
  localparam logic [4:0]  RST_PLOG    = 5'd18;
  localparam logic [15:0] RST_SEED    = 16'd44257;
  localparam logic [4:0]  MAX_PLOG    = 5'd24;

  localparam logic [1:0] REG_ALT_THR = 2'd0;
  localparam logic [1:0] REG_PLOG    = 2'd1;
  localparam logic [1:0] REG_SEED    = 2'd2;

  // reciprocal of 100 scaled by 2^22, rounded down
  localparam logic [15:0] RECIP100 = 16'd41943;

  typedef struct packed {
    logic [2:0]              ctr;
    logic [MAX_TAG_BITS-1:0] tag;
    logic [1:0]              u;
  } tbp_entry_t;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_READ, ST_EVAL, ST_WRITE, ST_HOLD, ST_SWEEP
  } tbp_state_t;

  typedef struct packed {
    logic clear;
    logic in_ready;
    logic accept;
    logic read;
    logic eval;
    logic commit;
    logic load_out;
    logic sweep;
  } tbp_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic sweep_done;
    logic tick_wrap;
    logic sweep_pend;
    logic out_free;
  } tbp_sts_t;

  function automatic logic [15:0] lfsr_step(input logic [15:0] v);
    logic [15:0] n;
    n = v >> 1;
    if (v[0]) begin
      n = n ^ LFSR_MASK;
    end
    return n;
  endfunction

  function automatic logic [15:0] fold(input logic [15:0] c, input logic t, input logic g,
                                       input int clen, input int sh);
    logic [16:0] v;
    v = ({c, 1'b0} | 17'(t)) ^ (17'(g) << sh);
    v = v ^ (v >> clen);
    return v[15:0] & ((16'd1 << clen) - 16'd1);
  endfunction

  function automatic logic [6:0] alloc_thr(input logic [2:0] k);
    logic [6:0] r;
    case (k)
      3'd2: r = 7'd49;
      3'd3: r = 7'd33;
      3'd4: r = 7'd24;
      3'd5: r = 7'd19;
      default: r = 7'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/tbp_ctrl.sv -----
// ----------------------------------------------------------------------------
// tbp_ctrl
// sequencer: reset clearing pass, per-branch read/eval/write, useful sweep
// ----------------------------------------------------------------------------
`default_nettype none

module tbp_ctrl
  import tbp_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     s_tvalid,
  input  wire tbp_sts_t sts,
  output tbp_cmd_t      cmd
);

  tbp_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        cmd.in_ready = 1'b1;
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        cmd.read = 1'b1;
        state_next = ST_EVAL;
      end
      ST_EVAL: begin
        cmd.eval = 1'b1;
        state_next = ST_WRITE;
      end
      ST_WRITE: begin
        cmd.commit = 1'b1;
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next = sts.tick_wrap ? ST_SWEEP : ST_IDLE;
        end else begin
          state_next = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next = sts.sweep_pend ? ST_SWEEP : ST_IDLE;
        end
      end
      ST_SWEEP: begin
        cmd.sweep = 1'b1;
        if (sts.sweep_done) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  a_accept_read: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> state == ST_READ) else $error("accept not followed by read");

  a_sweep_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SWEEP && sts.sweep_done) |=> state == ST_IDLE)
    else $error("sweep did not return to idle");

  a_hold_exit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_HOLD && sts.out_free) |=> (state == ST_IDLE || state == ST_SWEEP))
    else $error("held result not released");

  a_commit_once: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> !cmd.commit) else $error("double commit");

endmodule

`default_nettype wire

// ----- rtl/tbp_dp.sv -----
// ----------------------------------------------------------------------------
// tbp_dp
// datapath: tables, histories, folded registers, lfsr, counters, result register
// ----------------------------------------------------------------------------
`default_nettype none

module tbp_dp
  import tbp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire tbp_cmd_t    cmd,
  output tbp_sts_t         sts,
  input  wire logic [39:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,
  input  wire logic [3:0]  alt_thr,
  input  wire logic [4:0]  plog,
  input  wire logic        seed_load,
  input  wire logic [15:0] seed
);

  tbp_entry_t tmem [NUM_TAGGED][TAG_SIZE];
  logic [1:0] bmem [BIM_SIZE];
  tbp_entry_t rd [NUM_TAGGED];
  logic [1:0] brd;

  logic [130:0] ghist;
  logic [PATH_BITS-1:0] path;
  logic [TAG_IDX_BITS-1:0] fidx [NUM_TAGGED];
  logic [MAX_TAG_BITS-1:0] ft0 [NUM_TAGGED];
  logic [MAX_TAG_BITS-2:0] ft1 [NUM_TAGGED];
  logic [3:0]  uac;
  logic [23:0] tick;
  logic        clear_phase;
  logic [15:0] lfsr;
  logic [CLR_BITS-1:0]  ccnt;
  logic [UCNT_BITS-1:0] ucnt;
  logic        sweep_pend;

  logic [31:0] pc_r;
  logic        t_r;
  logic [TAG_IDX_BITS-1:0] idx_r [NUM_TAGGED];
  logic [MAX_TAG_BITS-1:0] tg_r [NUM_TAGGED];
  logic [9:0]  q_r;
  logic [6:0]  r_r;

  tbp_entry_t  new_e_r [NUM_TAGGED];
  logic [1:0]  bim_n_r;
  logic        pred_r, alloc_r, mis_r;
  logic [2:0]  prov_r;

  logic [31:0] in_pc;
  logic        in_t;
  logic [TAG_IDX_BITS-1:0] idx_c [NUM_TAGGED];
  logic [MAX_TAG_BITS-1:0] tg_c [NUM_TAGGED];
  logic [15:0] dv;
  logic [31:0] qprod;
  logic [16:0] rem;

  assign in_pc = s_tdata[31:0];
  assign in_t  = s_tdata[32];
  assign dv    = lfsr_step(lfsr);
  assign qprod = 32'(dv) * 32'(RECIP100);
  assign rem   = 17'(dv) - 17'(q_r) * 17'd100;

  always_comb begin
    for (int i = 0; i < NUM_TAGGED; i++) begin
      idx_c[i] = TAG_IDX_BITS'(in_pc ^ (in_pc >> (TAG_IDX_BITS - i)) ^ 32'(fidx[i])
                               ^ 32'(path >> (TAG_IDX_BITS - i)));
      tg_c[i] = (in_pc[MAX_TAG_BITS-1:0] ^ ft0[i] ^ {ft1[i], 1'b0})
                & MAX_TAG_BITS'((1 << TAG_W[i]) - 1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pc_r <= in_pc;
      t_r  <= in_t;
      idx_r <= idx_c;
      tg_r  <= tg_c;
      q_r   <= qprod[31:22];
    end
    if (cmd.read) begin
      r_r <= (rem >= 17'd100) ? 7'(rem - 17'd100) : rem[6:0];
    end
  end

  // evaluation
  logic [NUM_TAGGED-1:0] hit;
  logic [2:0] prov, alt;
  tbp_entry_t pe, ae;
  logic bim_p, ppred, apred, prov_weak, pred, pweak_n, train_alt, altgood, mis, empty;
  logic [2:0] pctr_n;
  logic [1:0] pu_n, au_n, au1;
  logic [3:0] uac_n;
  logic [1:0] bim_n;
  tbp_entry_t new_e [NUM_TAGGED];
  logic [NUM_TAGGED-1:0] alloc;

  always_comb begin
    prov = PROV_BIM;
    alt  = PROV_BIM;
    for (int i = NUM_TAGGED - 1; i >= 0; i--) begin
      hit[i] = rd[i].tag == tg_r[i];
      if (hit[i]) begin
        prov = 3'(i);
      end
    end
    for (int i = NUM_TAGGED - 1; i >= 0; i--) begin
      if (hit[i] && 3'(i) > prov) begin
        alt = 3'(i);
      end
    end
    pe = rd[prov[1:0]];
    ae = rd[alt[1:0]];
    bim_p = brd[1];
    ppred = pe.ctr >= WEAK_T;
    apred = alt[2] ? bim_p : (ae.ctr >= WEAK_T);
    prov_weak = (pe.ctr == WEAK_T || pe.ctr == WEAK_NT) && pe.u == 2'd0;
    pred  = prov[2] ? bim_p : ((prov_weak && uac >= alt_thr) ? apred : ppred);

    if (t_r) begin
      pctr_n = (pe.ctr != CTR_MAX) ? pe.ctr + 3'd1 : pe.ctr;
    end else begin
      pctr_n = (pe.ctr != 3'd0) ? pe.ctr - 3'd1 : pe.ctr;
    end
    if (ppred == t_r) begin
      pu_n = (pe.u != U_MAX) ? pe.u + 2'd1 : pe.u;
    end else begin
      pu_n = (pe.u != 2'd0) ? pe.u - 2'd1 : pe.u;
    end
    pweak_n   = (pctr_n == WEAK_T || pctr_n == WEAK_NT) && pu_n == 2'd0;
    train_alt = !prov[2] && pweak_n;
    altgood   = (ppred != apred) && (apred == t_r);

    uac_n = uac;
    au_n  = ae.u;
    au1   = ae.u;
    if (train_alt) begin
      if (altgood) begin
        uac_n = (uac != ALT_MAX) ? uac + 4'd1 : uac;
        if (t_r) begin
          au1 = (ae.u != U_MAX) ? ae.u + 2'd1 : ae.u;
        end else begin
          au1 = (ae.u != 2'd0) ? ae.u - 2'd1 : ae.u;
        end
        au_n = (au1 != U_MAX) ? au1 + 2'd1 : au1;
      end else begin
        uac_n = (uac != 4'd0) ? uac - 4'd1 : uac;
        au_n  = (ae.u != 2'd0) ? ae.u - 2'd1 : ae.u;
      end
    end

    bim_n = brd;
    if (prov[2]) begin
      if (t_r) begin
        bim_n = (brd != 2'd3) ? brd + 2'd1 : brd;
      end else begin
        bim_n = (brd != 2'd0) ? brd - 2'd1 : brd;
      end
    end

    mis = (prov != 3'd0) && (pred != t_r);
    empty = 1'b0;
    for (int i = 0; i < NUM_TAGGED; i++) begin
      if (3'(i) < prov && rd[i].u == 2'd0) begin
        empty = 1'b1;
      end
    end

    for (int i = 0; i < NUM_TAGGED; i++) begin
      new_e[i] = rd[i];
      if (prov == 3'(i)) begin
        new_e[i].ctr = pctr_n;
        new_e[i].u   = pu_n;
      end
      if (alt == 3'(i) && train_alt) begin
        new_e[i].u = au_n;
      end
      alloc[i] = 1'b0;
      if (mis) begin
        if (empty) begin
          alloc[i] = 3'(i) < prov && rd[i].u == 2'd0
                     && r_r <= alloc_thr(prov - 3'(i) + 3'd1);
        end else begin
          alloc[i] = dv[1:0] == 2'(i);
        end
      end
      if (alloc[i]) begin
        new_e[i].ctr = t_r ? WEAK_T : WEAK_NT;
        new_e[i].tag = tg_r[i];
        new_e[i].u   = 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      new_e_r <= new_e;
      bim_n_r <= bim_n;
      pred_r  <= pred;
      prov_r  <= prov;
      alloc_r <= |alloc;
      mis_r   <= mis;
    end
  end

  // memories
  logic [1:0] keep;
  logic [TAG_IDX_BITS-1:0] uprev;
  assign keep  = clear_phase ? 2'b01 : 2'b10;
  assign uprev = TAG_IDX_BITS'(ucnt - UCNT_BITS'(1));

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_TAGGED; i++) begin
      if (cmd.clear) begin
        tmem[i][ccnt[TAG_IDX_BITS-1:0]] <= '{ctr: WEAK_T, tag: '0, u: 2'd0};
      end else if (cmd.sweep && ucnt != '0) begin
        tmem[i][uprev] <= '{ctr: rd[i].ctr, tag: rd[i].tag, u: rd[i].u & keep};
      end else if (cmd.commit) begin
        tmem[i][idx_r[i]] <= new_e_r[i];
      end
      rd[i] <= tmem[i][cmd.sweep ? ucnt[TAG_IDX_BITS-1:0] : idx_r[i]];
    end
    if (cmd.clear) begin
      bmem[ccnt[BIM_IDX_BITS-1:0]] <= BIM_INIT;
    end else if (cmd.commit) begin
      bmem[pc_r[BIM_IDX_BITS-1:0]] <= bim_n_r;
    end
    brd <= bmem[pc_r[BIM_IDX_BITS-1:0]];
  end

  // control state
  logic [4:0]  lg;
  logic [24:0] tick_n;
  assign lg     = (plog > MAX_PLOG) ? MAX_PLOG : plog;
  assign tick_n = {1'b0, tick} + 25'd1;

  assign sts.clear_done = &ccnt;
  assign sts.sweep_done = ucnt == UCNT_BITS'(TAG_SIZE);
  assign sts.tick_wrap  = tick_n >= (25'd1 << lg);
  assign sts.sweep_pend = sweep_pend;
  assign sts.out_free   = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ghist <= '0;
      path  <= '0;
      for (int i = 0; i < NUM_TAGGED; i++) begin
        fidx[i] <= '0;
        ft0[i]  <= '0;
        ft1[i]  <= '0;
      end
      uac <= ALT_INIT;
      tick <= '0;
      clear_phase <= 1'b1;
      lfsr <= RST_SEED;
      ccnt <= '0;
      ucnt <= '0;
      sweep_pend <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.clear) begin
        ccnt <= ccnt + CLR_BITS'(1);
      end
      if (seed_load) begin
        lfsr <= (seed == 16'd0) ? 16'd1 : seed;
      end else if (cmd.commit && mis_r) begin
        lfsr <= dv;
      end
      if (cmd.eval) begin
        uac <= uac_n;
      end
      if (cmd.commit) begin
        ghist <= {ghist[129:0], t_r};
        path  <= {path[PATH_BITS-2:0], t_r};
        for (int i = 0; i < NUM_TAGGED; i++) begin
          fidx[i] <= TAG_IDX_BITS'(fold(16'(fidx[i]), t_r, ghist[HIST[i]-1],
                                        TAG_IDX_BITS, FI_SH[i]));
          ft0[i]  <= MAX_TAG_BITS'(fold(16'(ft0[i]), t_r, ghist[HIST[i]-1],
                                        TAG_W[i], FT0_SH[i]));
          ft1[i]  <= (MAX_TAG_BITS-1)'(fold(16'(ft1[i]), t_r, ghist[HIST[i]-1],
                                            TAG_W[i] - 1, FT1_SH[i]));
        end
        if (sts.tick_wrap) begin
          tick <= '0;
          sweep_pend <= 1'b1;
        end else begin
          tick <= tick_n[23:0];
        end
      end
      if (cmd.sweep) begin
        if (sts.sweep_done) begin
          ucnt <= '0;
          clear_phase <= !clear_phase;
          sweep_pend <= 1'b0;
        end else begin
          ucnt <= ucnt + UCNT_BITS'(1);
        end
      end
      if (cmd.load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_tdata <= {3'b000, alloc_r, prov_r, pred_r};
    end
  end

endmodule

`default_nettype wire

// ----- rtl/tage_branch_predictor_unit.sv -----
// ----------------------------------------------------------------------------
// tage_branch_predictor_unit
// tage conditional branch predictor with apb configuration and stream ports
// ----------------------------------------------------------------------------
// result path: after request accept, the read, eval and write states precede result valid
// intake: a new branch is taken only in idle, once the previous table read-modify-write is done
// useful clear: every 2^plog branches (plog capped at 24) intake stalls for a table sweep
// reset: a clearing pass over the tables runs before the first request is taken
`default_nettype none

module tage_branch_predictor_unit
  import tbp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,  // pc[31:0], taken[32]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,  // predicted_taken[0], provider_table[3:1], allocated[4]
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  tbp_cmd_t cmd;
  tbp_sts_t sts;
  logic [3:0]  alt_thr;
  logic [4:0]  plog;
  logic [15:0] seed;
  logic        wr;
  logic [1:0]  ridx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign ridx   = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      alt_thr <= RST_ALT_THR;
      plog    <= RST_PLOG;
      seed    <= RST_SEED;
    end else if (wr) begin
      case (ridx)
        REG_ALT_THR: alt_thr <= pwdata[3:0];
        REG_PLOG:    plog    <= pwdata[4:0];
        REG_SEED:    seed    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_ALT_THR: prdata = {28'd0, alt_thr};
      REG_PLOG:    prdata = {27'd0, plog};
      REG_SEED:    prdata = {16'd0, seed};
      default:     prdata = '0;
    endcase
  end

  assign s_tready = cmd.in_ready;

  tbp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .sts      (sts),
    .cmd      (cmd)
  );

  tbp_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .alt_thr   (alt_thr),
    .plog      (plog),
    .seed_load (wr && ridx == REG_SEED),
    .seed      (pwdata[15:0])
  );

endmodule

`default_nettype wire

// ----- verif/tage_branch_predictor_unit_test.sv -----
// ----------------------------------------------------------------------------
// tage_branch_predictor_unit_test
// self-checking testbench: branches are streamed in, a behavioral copy of the
// predictor computes each expected outcome and every response is compared
// field by field, across several register settings and random stalls
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tage_branch_predictor_unit_test;
  import tbp_pkg::*;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int SETTLE_CYCLES = 1100;
  localparam int POOL = 16;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  tage_branch_predictor_unit u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // predictor copy
  logic [2:0]  tab_ctr [NUM_TAGGED][TAG_SIZE];
  logic [11:0] tab_tag [NUM_TAGGED][TAG_SIZE];
  logic [1:0]  tab_u   [NUM_TAGGED][TAG_SIZE];
  logic [1:0]  bim_ctr [BIM_SIZE];
  logic        ghist [LONGEST+1];
  logic [15:0] path_h;
  logic [31:0] fidx [NUM_TAGGED];
  logic [31:0] ftag0 [NUM_TAGGED];
  logic [31:0] ftag1 [NUM_TAGGED];
  logic [3:0]  alt_cnt;
  int unsigned ticks;
  logic        clr_phase;
  logic [15:0] lfsr;
  logic [3:0]  cfg_thr;
  logic [4:0]  cfg_plog;

  logic [4:0] pending_outcomes [$];  // allocated, provider[2:0], predicted
  bit failed = 1'b0;
  bit idle_on = 1'b0;
  int unsigned cycles = 0;

  logic [31:0] pool_pc [POOL];
  int          pool_kind [POOL];
  int          pool_cnt [POOL];

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tage_branch_predictor_unit verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    m_tready <= idle_on ? ($urandom_range(0, 99) >= 8) : 1'b1;
  end

  always @(posedge clk) begin
    logic [4:0] exp_o;
    if (m_tvalid && m_tready) begin
      if (pending_outcomes.size() == 0) begin
        $display("%0t: unexpected response %h", $time, m_tdata);
        failed = 1'b1;
      end else begin
        exp_o = pending_outcomes.pop_front();
        if (m_tdata[0] !== exp_o[0]) begin
          $display("%0t: predicted_taken exp %0d got %0d", $time, exp_o[0], m_tdata[0]);
          failed = 1'b1;
        end
        if (m_tdata[3:1] !== exp_o[3:1]) begin
          $display("%0t: provider_table exp %0d got %0d", $time, exp_o[3:1], m_tdata[3:1]);
          failed = 1'b1;
        end
        if (m_tdata[4] !== exp_o[4]) begin
          $display("%0t: allocated exp %0d got %0d", $time, exp_o[4], m_tdata[4]);
          failed = 1'b1;
        end
      end
    end
  end

  function automatic int tag_bits(input int i);
    return (i == 3) ? MAX_TAG_BITS - 1 : MAX_TAG_BITS;
  endfunction

  function automatic logic [15:0] next_rand();
    logic lsb;
    lsb = lfsr[0];
    lfsr = lfsr >> 1;
    if (lsb) lfsr = lfsr ^ 16'hB400;
    return lfsr;
  endfunction

  function automatic logic [31:0] fold_hist(input logic [31:0] c, input int orig,
                                            input int clen);
    logic [31:0] v;
    v = (c << 1) | 32'(ghist[0]);
    v = v ^ (32'(ghist[orig]) << (orig % clen));
    v = v ^ (v >> clen);
    return v & ((32'd1 << clen) - 32'd1);
  endfunction

  task automatic reset_model();
    for (int i = 0; i < NUM_TAGGED; i++) begin
      for (int j = 0; j < TAG_SIZE; j++) begin
        tab_ctr[i][j] = 3'd4;
        tab_tag[i][j] = '0;
        tab_u[i][j] = '0;
      end
      fidx[i] = '0;
      ftag0[i] = '0;
      ftag1[i] = '0;
    end
    for (int j = 0; j < BIM_SIZE; j++) bim_ctr[j] = 2'd2;
    for (int j = 0; j <= LONGEST; j++) ghist[j] = 1'b0;
    path_h = '0;
    alt_cnt = 4'd8;
    ticks = 0;
    clr_phase = 1'b1;
    cfg_thr = 4'd8;
    cfg_plog = 5'd18;
    lfsr = 16'd44257;
  endtask

  task automatic predict_branch(input logic [31:0] pc, input logic tk);
    int idx [NUM_TAGGED];
    logic [31:0] tg32;
    logic [11:0] tg [NUM_TAGGED];
    int prov, alt, pi, ai, s, lg, bidx;
    logic bim, ppred, apred, pred, alloc, prov_weak, empty;
    int unsigned r, period;
    logic [1:0] keep;
    prov = NUM_TAGGED;
    alt = NUM_TAGGED;
    ppred = 1'b0;
    apred = 1'b0;
    alloc = 1'b0;
    pi = 0;
    if (lfsr == 0) lfsr = 16'd1;
    for (int i = 0; i < NUM_TAGGED; i++) begin
      tg32 = (pc ^ ftag0[i] ^ (ftag1[i] << 1)) & ((32'd1 << tag_bits(i)) - 32'd1);
      tg[i] = tg32[11:0];
      tg32 = (pc ^ (pc >> (10 - i)) ^ fidx[i] ^ ({16'b0, path_h} >> (10 - i))) & 32'd1023;
      idx[i] = int'(tg32);
    end
    for (int i = 0; i < NUM_TAGGED; i++)
      if (prov == NUM_TAGGED && tab_tag[i][idx[i]] == tg[i]) prov = i;
    for (int i = prov + 1; i < NUM_TAGGED; i++)
      if (alt == NUM_TAGGED && tab_tag[i][idx[i]] == tg[i]) alt = i;
    bidx = int'(pc[11:0]);
    bim = bim_ctr[bidx] >= 2;
    if (prov == NUM_TAGGED) begin
      pred = bim;
    end else begin
      pi = idx[prov];
      ppred = tab_ctr[prov][pi] >= 4;
      apred = (alt == NUM_TAGGED) ? bim : (tab_ctr[alt][idx[alt]] >= 4);
      prov_weak = (tab_ctr[prov][pi] == 4 || tab_ctr[prov][pi] == 3) && tab_u[prov][pi] == 0;
      pred = (prov_weak && alt_cnt >= cfg_thr) ? apred : ppred;
    end
    // training
    if (prov == NUM_TAGGED) begin
      if (tk) begin
        if (bim_ctr[bidx] < 3) bim_ctr[bidx]++;
      end else if (bim_ctr[bidx] > 0) bim_ctr[bidx]--;
    end else begin
      if (tk) begin
        if (tab_ctr[prov][pi] < 7) tab_ctr[prov][pi]++;
      end else if (tab_ctr[prov][pi] > 0) tab_ctr[prov][pi]--;
      if (ppred == tk) begin
        if (tab_u[prov][pi] < 3) tab_u[prov][pi]++;
      end else if (tab_u[prov][pi] > 0) tab_u[prov][pi]--;
      if ((tab_ctr[prov][pi] == 4 || tab_ctr[prov][pi] == 3) && tab_u[prov][pi] == 0) begin
        ai = (alt == NUM_TAGGED) ? 0 : idx[alt];
        if (ppred != apred && apred == tk) begin
          if (alt_cnt < 15) alt_cnt++;
          if (alt != NUM_TAGGED) begin
            if (tk) begin
              if (tab_u[alt][ai] < 3) tab_u[alt][ai]++;
            end else if (tab_u[alt][ai] > 0) tab_u[alt][ai]--;
            if (tab_u[alt][ai] < 3) tab_u[alt][ai]++;
          end
        end else begin
          if (alt_cnt > 0) alt_cnt--;
          if (alt != NUM_TAGGED && tab_u[alt][ai] > 0) tab_u[alt][ai]--;
        end
      end
    end
    // allocation on mispredict
    if (prov > 0 && pred != tk) begin
      empty = 1'b0;
      for (int i = 0; i < prov; i++)
        if (tab_u[i][idx[i]] == 0) empty = 1'b1;
      if (empty) begin
        r = next_rand() % 100;
        for (int i = prov - 1; i >= 0; i--) begin
          if (tab_u[i][idx[i]] == 0 && r <= 99 / (prov - i + 1)) begin
            tab_ctr[i][idx[i]] = tk ? 3'd4 : 3'd3;
            tab_tag[i][idx[i]] = tg[i];
            tab_u[i][idx[i]] = '0;
            alloc = 1'b1;
          end
        end
      end else begin
        s = int'(next_rand() % 4);
        tab_ctr[s][idx[s]] = tk ? 3'd4 : 3'd3;
        tab_tag[s][idx[s]] = tg[s];
        tab_u[s][idx[s]] = '0;
        alloc = 1'b1;
      end
    end
    // histories
    for (int k = LONGEST; k > 0; k--) ghist[k] = ghist[k-1];
    ghist[0] = tk;
    path_h = {path_h[14:0], tk};
    for (int i = 0; i < NUM_TAGGED; i++) begin
      fidx[i] = fold_hist(fidx[i], HIST[i], TAG_IDX_BITS);
      ftag0[i] = fold_hist(ftag0[i], HIST[i], tag_bits(i));
      ftag1[i] = fold_hist(ftag1[i], HIST[i], tag_bits(i) - 1);
    end
    // periodic useful clear
    lg = (cfg_plog > 24) ? 24 : int'(cfg_plog);
    period = 32'd1 << lg;
    if (ticks + 1 >= period) begin
      keep = clr_phase ? 2'd1 : 2'd2;
      for (int k = 0; k < NUM_TAGGED; k++)
        for (int j = 0; j < TAG_SIZE; j++) tab_u[k][j] = tab_u[k][j] & keep;
      clr_phase = ~clr_phase;
      ticks = 0;
    end else begin
      ticks = ticks + 1;
    end
    pending_outcomes.push_back({alloc, 3'(prov), pred});
  endtask

  task automatic send_branch(input logic [31:0] pc, input logic tk);
    if (idle_on && $urandom_range(0, 99) < 8) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {7'b0, tk, pc};
    do @(posedge clk); while (!s_tready);
    predict_branch(pc, tk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {index, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (index)
      REG_ALT_THR: cfg_thr = value[3:0];
      REG_PLOG: cfg_plog = value[4:0];
      REG_SEED: lfsr = (value[15:0] == 0) ? 16'd1 : value[15:0];
      default: ;
    endcase
  endtask

  task automatic init_pool();
    for (int i = 0; i < POOL; i++) begin
      pool_pc[i] = $urandom();
      pool_kind[i] = $urandom_range(0, 4);
      pool_cnt[i] = 0;
    end
  endtask

  // mostly recurring branches with learnable behavior, some noise
  task automatic send_random(input int n);
    int p;
    logic tk;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 99) < 80) begin
        p = $urandom_range(0, POOL - 1);
        pool_cnt[p]++;
        case (pool_kind[p])
          0: tk = $urandom_range(0, 9) != 0;
          1: tk = (pool_cnt[p] % 7) != 0;
          2: tk = pool_cnt[p][0];
          3: tk = ghist[0] ^ ghist[2];
          default: tk = $urandom_range(0, 1);
        endcase
        send_branch(pool_pc[p], tk);
      end else begin
        send_branch($urandom(), $urandom_range(0, 1));
      end
    end
  endtask

  task automatic test_field_extremes();
    send_branch(32'h0000_0000, 1'b0);
    send_branch(32'h0000_0000, 1'b1);
    send_branch(32'hFFFF_FFFF, 1'b1);
    send_branch(32'hFFFF_FFFF, 1'b0);
    send_branch(32'hAAAA_AAAA, 1'b1);
    send_branch(32'h5555_5555, 1'b0);
    for (int k = 0; k < 4; k++) send_branch(32'h0000_1234, 1'b1);
    send_branch(32'h0000_1234, 1'b0);
    drain();
  endtask

  task automatic test_short_period();
    write_reg(REG_PLOG, 32'd0);
    for (int k = 0; k < 3; k++) send_branch($urandom(), $urandom_range(0, 1));
    drain();
    write_reg(REG_PLOG, 32'd1);
    for (int k = 0; k < 4; k++) send_branch($urandom(), $urandom_range(0, 1));
    drain();
    write_reg(REG_PLOG, 32'd31);
    for (int k = 0; k < 3; k++) send_branch($urandom(), $urandom_range(0, 1));
    drain();
  endtask

  task automatic test_threshold_and_seed();
    write_reg(REG_ALT_THR, 32'd0);
    write_reg(REG_SEED, 32'd0);
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    send_random(4);
    drain();
    write_reg(REG_ALT_THR, 32'd15);
    write_reg(REG_SEED, 32'hFFFF);
    send_random(4);
    drain();
  endtask

  task automatic test_random_phases();
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_ALT_THR, $urandom_range(0, 15));
      write_reg(REG_PLOG, $urandom_range(4, 24));
      write_reg(REG_SEED, $urandom_range(0, 65535));
      send_random(70);
      drain();
    end
  endtask

  task automatic test_no_idle_stretch();
    idle_on = 1'b0;
    write_reg(REG_PLOG, 32'd24);
    send_random(70);
    idle_on = 1'b1;
  endtask

  task automatic test_pause_until_empty();
    send_random(20);
    s_tvalid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    send_random(30);
    drain();
  endtask

  initial begin
    reset_model();
    init_pool();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_field_extremes();
    idle_on = 1'b1;
    test_short_period();
    test_threshold_and_seed();
    test_random_phases();
    test_no_idle_stretch();
    test_pause_until_empty();
    if (!failed && pending_outcomes.size() == 0) begin
      $display("tage_branch_predictor_unit verification clean");
    end else begin
      $display("tage_branch_predictor_unit verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
